// ===== sv/binary_subarray_sum_counter_core_defines.svh =====
// Assertion macros shared by the checking code of the core.
`ifndef BINARY_SUBARRAY_SUM_COUNTER_CORE_DEFINES_SVH
`define BINARY_SUBARRAY_SUM_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bsc_pkg.sv =====
`timescale 1ns / 1ps
package bsc_pkg;

  localparam int GOAL_W = 13;
  localparam int HIST_W = 13;
  localparam int ANS_W  = 24;

  localparam logic [HIST_W-1:0] HIST_MAX   = '1;
  localparam logic [ANS_W-1:0]  ANSWER_MAX = '1;

  typedef struct packed {
    logic bit_value;
    logic is_last;
  } bsc_in_t;

  typedef struct packed {
    logic [ANS_W-1:0] run_count;
    logic             seq_end;
    logic             too_long;
  } bsc_out_t;

  // Per-beat control handed from the address stage to the accumulate stage
  typedef struct packed {
    logic              sel_mem;
    logic [HIST_W-1:0] byp_val;
    logic              last;
    logic              flag;
  } bsc_stg_t;

endpackage

// ===== sv/bsc_hist_ram.sv =====
`timescale 1ns / 1ps
module bsc_hist_ram #(
  parameter int DEPTH = 4097
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr,
  output logic [bsc_pkg::HIST_W-1:0]          rd_data,
  input  logic                                wr_en,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr,
  input  logic [bsc_pkg::HIST_W-1:0]          wr_data
);
  import bsc_pkg::*;

  logic [HIST_W-1:0] mem [DEPTH];
  logic [HIST_W-1:0] rd_data_r;

  // Write port; read port returns old data on a same-address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/bsc_ctrl.sv =====
`timescale 1ns / 1ps
module bsc_ctrl #(
  parameter int MAX_LEN = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [bsc_pkg::GOAL_W-1:0]          cfg_wr_data,
  input  logic                                fire,
  input  bsc_pkg::bsc_in_t                    in_data,
  output bsc_pkg::bsc_stg_t                   stg,
  output logic [$clog2(MAX_LEN+1)-1:0]        rd_addr,
  output logic                                wr_en,
  output logic [$clog2(MAX_LEN+1)-1:0]        wr_addr,
  output logic [bsc_pkg::HIST_W-1:0]          wr_data
);
  import bsc_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int SW = ((CW > GOAL_W) ? CW : GOAL_W) + 1;

  logic [GOAL_W-1:0] target_r;
  logic [GOAL_W-1:0] goal_r,  goal_nxt;
  logic [CW-1:0]     cnt_r,   cnt_nxt;
  logic [CW-1:0]     pfx_r,   pfx_nxt;
  logic [HIST_W-1:0] run_r,   run_nxt;
  logic              lead_r,  lead_nxt;

  logic              first, full;
  logic [GOAL_W-1:0] goal_cur;
  logic [HIST_W-1:0] run_old, run_new;
  logic [CW-1:0]     pfx_new;
  logic [SW-1:0]     win_hi, win_lo, rd_ext, wr_sum;

  // Hold the goal register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_wr_en) begin
      target_r <= cfg_wr_data;
    end
  end

  // Derive this beat's prefix, zero-run count and table window
  always_comb begin
    first    = (cnt_r == '0);
    full     = (cnt_r >= CW'(MAX_LEN));
    goal_cur = first ? target_r : goal_r;
    run_old  = first ? HIST_W'(1) : run_r;
    pfx_new  = pfx_r + CW'(in_data.bit_value);
    if (in_data.bit_value) begin
      run_new = HIST_W'(1);
    end else begin
      run_new = (run_old == HIST_MAX) ? run_old : run_old + HIST_W'(1);
    end
    win_lo = SW'(goal_cur);
    win_hi = SW'(goal_cur) + SW'(pfx_r);
    rd_ext = SW'(pfx_new);
    wr_sum = SW'(goal_cur) + SW'(pfx_new);
  end

  // Pick memory, the live zero-run count, the unwritten seed, or zero for the lookup
  always_comb begin
    stg.last    = in_data.is_last;
    stg.flag    = full;
    stg.sel_mem = 1'b0;
    stg.byp_val = '0;
    if (!full) begin
      if (rd_ext == win_hi) begin
        stg.byp_val = run_old;
      end else if (lead_r && rd_ext == win_lo) begin
        stg.byp_val = HIST_W'(1);
      end else if (rd_ext >= win_lo && rd_ext < win_hi) begin
        stg.sel_mem = 1'b1;
      end
    end
  end

  // Table write of the bumped entry; drop indices past the table
  assign rd_addr = pfx_new;
  assign wr_en   = fire && !full && (wr_sum <= SW'(MAX_LEN));
  assign wr_addr = wr_sum[CW-1:0];
  assign wr_data = run_new;

  // Advance sequence state, clear on the last beat
  always_comb begin
    cnt_nxt  = cnt_r;
    pfx_nxt  = pfx_r;
    run_nxt  = run_r;
    goal_nxt = goal_r;
    lead_nxt = lead_r;
    if (fire) begin
      if (!full) begin
        cnt_nxt  = cnt_r + CW'(1);
        pfx_nxt  = pfx_new;
        run_nxt  = run_new;
        goal_nxt = goal_cur;
        // A sequence that opens on a one never writes its seed entry
        if (first) begin
          lead_nxt = in_data.bit_value;
        end
      end
      if (in_data.is_last) begin
        cnt_nxt  = '0;
        pfx_nxt  = '0;
        run_nxt  = '0;
        goal_nxt = '0;
        lead_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pfx_r  <= '0;
      run_r  <= '0;
      goal_r <= '0;
      lead_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pfx_r  <= pfx_nxt;
      run_r  <= run_nxt;
      goal_r <= goal_nxt;
      lead_r <= lead_nxt;
    end
  end

endmodule

// ===== sv/bsc_accum.sv =====
`timescale 1ns / 1ps
module bsc_accum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s_valid,
  input  bsc_pkg::bsc_stg_t           s_stg,
  output logic                        s_ready,
  input  logic [bsc_pkg::HIST_W-1:0]  rd_data,
  output logic                        b_vld,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bsc_pkg::bsc_out_t           out_data
);
  import bsc_pkg::*;

  logic              b_vld_r,  b_vld_nxt;
  bsc_stg_t          b_stg_r;
  logic [ANS_W-1:0]  ans_r,    ans_nxt;
  logic              out_vld_r, out_vld_nxt;
  bsc_out_t          out_r;

  logic              b_adv, b_fire;
  logic [HIST_W-1:0] add;
  logic [ANS_W:0]    sum;
  logic [ANS_W-1:0]  ans_sat;

  assign b_adv   = !out_vld_r || out_ready;
  assign b_fire  = b_vld_r && b_adv;
  assign s_ready = !b_vld_r || b_adv;

  // Add the looked-up count to the running answer, saturating
  always_comb begin
    add     = b_stg_r.sel_mem ? rd_data : b_stg_r.byp_val;
    sum     = {1'b0, ans_r} + (ANS_W+1)'(add);
    ans_sat = sum[ANS_W] ? ANSWER_MAX : sum[ANS_W-1:0];
    ans_nxt = ans_r;
    if (b_fire) begin
      ans_nxt = b_stg_r.last ? '0 : ans_sat;
    end
  end

  // Stage and output valid flags
  always_comb begin
    b_vld_nxt = b_vld_r;
    if (s_valid && s_ready) begin
      b_vld_nxt = 1'b1;
    end else if (b_fire) begin
      b_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (b_fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      ans_r     <= '0;
    end else begin
      b_vld_r   <= b_vld_nxt;
      out_vld_r <= out_vld_nxt;
      ans_r     <= ans_nxt;
    end
  end

  // Capture the beat's control and the finished result
  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      b_stg_r <= s_stg;
    end
    if (b_fire) begin
      out_r.run_count <= ans_sat;
      out_r.seq_end   <= b_stg_r.last;
      out_r.too_long  <= b_stg_r.flag;
    end
  end

  assign b_vld     = b_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== sv/binary_subarray_sum_counter_core.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                Beat
// input     in_valid / in_ready / in_data        one 0/1 element and its last mark
// result    out_valid / out_ready / out_data     running run count, end and overflow flags
// config    cfg_wr_en / cfg_wr_data              goal sum, picked up at a sequence start
//
// One beat per cycle unless the result stalls; middle stage, then result register.
// The prefix table is a single-port-write, single-port-read RAM of MAX_LEN+1 entries;
// the lookup and the bump of one beat share a cycle, with the live entry in a register.
// Stale table entries outside the written window read as zero, so no clearing pass.
// Reset is synchronous; a stalled result holds the middle stage, then the input.
module binary_subarray_sum_counter_core #(
  parameter int MAX_LEN = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bsc_pkg::bsc_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bsc_pkg::bsc_out_t          out_data,
  input  logic                       cfg_wr_en,
  input  logic [bsc_pkg::GOAL_W-1:0] cfg_wr_data
);
  import bsc_pkg::*;

`include "binary_subarray_sum_counter_core_defines.svh"

  localparam int CW = $clog2(MAX_LEN + 1);

  logic              in_fire;
  bsc_stg_t          stg;
  logic [CW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  logic [HIST_W-1:0] wr_data, rd_data;
  logic              b_vld;

  assign in_fire = in_valid && in_ready;

  bsc_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (in_fire),
    .in_data     (in_data),
    .stg         (stg),
    .rd_addr     (rd_addr),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  bsc_hist_ram #(.DEPTH(MAX_LEN + 1)) u_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bsc_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (in_valid),
    .s_stg     (stg),
    .s_ready   (in_ready),
    .rd_data   (rd_data),
    .b_vld     (b_vld),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Check stage flow
  `BSC_ASSERT_NOW(a_stall_blocks_in, b_vld && out_valid && !out_ready, !in_ready, "input taken while middle stage is stalled")
  `BSC_ASSERT_NEXT(a_beat_lands, in_fire, b_vld, "accepted beat missing from middle stage")
  `BSC_ASSERT_NEXT(a_stage_holds, b_vld && out_valid && !out_ready, b_vld, "stalled middle stage lost its beat")
  `BSC_ASSERT_NOW(a_no_write_idle, wr_en, in_fire, "table written without an accepted beat")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import bsc_pkg::*;

  localparam int LEN_CAP      = 4096;
  localparam int RANDOM_ITEMS = 950;
  localparam int STALL_LIMIT  = 1000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PULSE
  } rx_mode_t;

  // Prefix-histogram predictor of the run count, with the queue of results it expects
  class run_count_board;
    logic [GOAL_W-1:0] goal;
    int unsigned       seq_goal;
    int unsigned       prefix;
    int unsigned       taken;
    logic [ANS_W-1:0]  answer;
    logic [HIST_W-1:0] hist [0:LEN_CAP];
    bsc_out_t          expected_runs[$];
    int                errors;

    function new();
      goal   = '0;
      errors = 0;
      clear_seq();
    endfunction

    function void clear_seq();
      seq_goal = 0;
      prefix   = 0;
      taken    = 0;
      answer   = '0;
      foreach (hist[i]) hist[i] = '0;
    endfunction

    function void set_goal(logic [GOAL_W-1:0] g);
      goal = g;
    endfunction

    // Drop bumps beyond the table and hold entries at their ceiling
    function void bump(int unsigned idx);
      if (idx <= LEN_CAP && hist[idx] != HIST_MAX) hist[idx] = hist[idx] + 1'b1;
    endfunction

    function int pending();
      return expected_runs.size();
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Advance the prefix state by one accepted beat and queue its result
    task note_beat(bsc_in_t d);
      bsc_out_t    exp_beat;
      int unsigned sum;
      exp_beat = '0;
      if (taken >= LEN_CAP) begin
        exp_beat.too_long = 1'b1;
      end else begin
        if (taken == 0) begin
          seq_goal = goal;
          bump(seq_goal);
        end
        taken++;
        prefix += d.bit_value;
        if (prefix <= LEN_CAP) begin
          sum = answer + hist[prefix];
          answer = (sum > ANSWER_MAX) ? ANSWER_MAX : sum[ANS_W-1:0];
        end
        bump(prefix + seq_goal);
      end
      exp_beat.run_count = answer;
      exp_beat.seq_end   = d.is_last;
      expected_runs.push_back(exp_beat);
      if (d.is_last) clear_seq();
    endtask

    // Compare one result beat with the oldest expectation
    task check_beat(bsc_out_t got);
      bsc_out_t want;
      if (expected_runs.size() == 0) begin
        report($sformatf("result beat with nothing expected (run_count %0d)", got.run_count));
      end else begin
        want = expected_runs.pop_front();
        if (got.run_count !== want.run_count)
          report($sformatf("run_count got %0d want %0d", got.run_count, want.run_count));
        if (got.seq_end !== want.seq_end)
          report($sformatf("seq_end got %b want %b", got.seq_end, want.seq_end));
        if (got.too_long !== want.too_long)
          report($sformatf("too_long got %b want %b", got.too_long, want.too_long));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  bsc_in_t           in_data;
  logic              out_valid;
  logic              out_ready = 1'b0;
  bsc_out_t          out_data;
  logic              cfg_wr_en;
  logic [GOAL_W-1:0] cfg_wr_data;

  run_count_board sb = new();
  int             burst_left = 0;
  int             rx_tick = 0;
  rx_mode_t       rx_mode = RX_OPEN;

  binary_subarray_sum_counter_core #(
    .MAX_LEN(LEN_CAP)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both channels on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready === 1'b1) sb.note_beat(in_data);
      if (out_valid === 1'b1 && out_ready) sb.check_beat(out_data);
    end
  end

  // Receiver: pick one of four stall patterns at random and switch it periodically
  always @(negedge clk) begin
    if (rx_tick % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: rx_mode = RX_OPEN;
        1: rx_mode = RX_COIN;
        2: rx_mode = RX_SPARSE;
        default: rx_mode = RX_PULSE;
      endcase
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= rx_tick[2];
    endcase
  end

  // Watchdog: end the run if no beat moves for too long
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("binary_subarray_sum_counter_core regression: fail");
    $finish;
  end

  // Send one element, opening a random gap at the end of each burst
  task automatic send_elem(logic b, logic last);
    bsc_in_t d;
    int      gap;
    d.bit_value = b;
    d.is_last   = last;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic send_run(logic [31:0] bits, int len, bit close);
    for (int i = 0; i < len; i++) send_elem(bits[i], close && (i == len - 1));
  endtask

  // Hold the sender until every expected result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_goal(logic [GOAL_W-1:0] g);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= g;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_goal(g);
  endtask

  initial begin
    int          sent;
    int          len;
    int          n_seq;
    int          ones_pct;
    bit          leave_open;
    logic [12:0] g;

    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    rst_n       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Goal zero from reset: runs of zeros
    send_run(32'b0100, 4, 1'b1);
    wait_idle();
    write_goal(13'd1);
    send_run(32'b10101, 5, 1'b1);
    send_elem(1'b1, 1'b1);
    wait_idle();

    // Rewrite the goal inside an open sequence: latched goal stays
    write_goal(13'd2);
    send_run(32'b11, 2, 1'b0);
    wait_idle();
    write_goal(13'd3);
    send_run(32'b101, 3, 1'b1);
    wait_idle();

    // Goals beyond reach of any prefix
    write_goal(13'h1FFF);
    send_run(32'b011, 3, 1'b1);
    wait_idle();
    write_goal(GOAL_W'(LEN_CAP));
    send_run(32'b01, 2, 1'b1);
    wait_idle();

    // Random phases of well-formed sequences, some left open across a goal write
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: g = '0;
        1: g = 13'h1FFF;
        2: g = GOAL_W'(LEN_CAP);
        3: g = 13'($urandom_range(0, 8191));
        default: g = 13'($urandom_range(0, 5));
      endcase
      write_goal(g);
      n_seq = $urandom_range(1, 4);
      leave_open = ($urandom_range(0, 3) == 0);
      for (int s = 0; s < n_seq; s++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        case ($urandom_range(0, 4))
          0: ones_pct = 0;
          1: ones_pct = 10;
          2: ones_pct = 50;
          3: ones_pct = 90;
          default: ones_pct = 100;
        endcase
        for (int i = 0; i < len; i++) begin
          send_elem($urandom_range(0, 99) < ones_pct,
                    (i == len - 1) && !(leave_open && s == n_seq - 1));
          sent++;
        end
      end
      wait_idle();
    end

    // Close whatever is still open, then drain
    send_elem(1'b1, 1'b1);
    wait_idle();
    repeat (10) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d expected results never came", sb.pending()));

    if (sb.errors == 0) begin
      $display("binary_subarray_sum_counter_core regression: pass");
    end else begin
      $display("binary_subarray_sum_counter_core regression: fail");
    end
    $finish;
  end

endmodule
